// File: rtl/utf8_glyph_index_mapper_assert.svh
// assertion macros shared by the utf8 glyph index mapper checkers
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef UTF8_GLYPH_INDEX_MAPPER_ASSERT_SVH
`define UTF8_GLYPH_INDEX_MAPPER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define U8GIM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define U8GIM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8gim_pkg.sv
// package for the utf8 glyph index mapper: constants, result type, code mapping
// no dependencies
package u8gim_pkg;

    // glyph given to any code without a rule
    localparam logic [7:0] GLYPH_UNKNOWN = 8'd162;

    // lead byte prefixes
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [4:0] LEAD4_PFX = 5'b11110;

    typedef struct packed {
        logic [7:0] glyph;
        logic       font;
    } glyph_res_t;

    // map a complete packed code to a glyph and font
    function automatic glyph_res_t map_code(input logic [31:0] code_in);
        glyph_res_t res;
        logic [31:0] c;
        logic [7:0]  lo;
        res.font  = 1'b0;
        res.glyph = GLYPH_UNKNOWN;
        c         = code_in;
        if (c == 32'h7F) begin
            c = 32'd32;
        end
        lo = c[7:0];
        if (c >= 32'd1 && c <= 32'd9) begin
            res.font  = 1'b1;
            res.glyph = lo - 8'd1;
        end else if (c < 32'h7F) begin
            res.glyph = (c >= 32'd32) ? (lo - 8'd32) : GLYPH_UNKNOWN;
        end else if (c >= 32'hD090 && c <= 32'hD0BF) begin
            res.glyph = lo - 8'h90 + 8'd95;
        end else if (c >= 32'hD180 && c <= 32'hD18F) begin
            res.glyph = lo - 8'h80 + 8'd143;
        end else if (c == 32'hD081) begin
            res.glyph = 8'd159;
        end else if (c == 32'hD191) begin
            res.glyph = 8'd160;
        end else if (c >= 32'hD084 && c <= 32'hD087) begin
            res.glyph = lo - 8'h84 + 8'd161;
        end else if (c >= 32'hD194 && c <= 32'hD197) begin
            res.glyph = lo - 8'h94 + 8'd165;
        end else if (c == 32'hD290 || c == 32'hD291) begin
            res.glyph = lo - 8'h90 + 8'd169;
        end else if (c == 32'hC2B0) begin
            res.glyph = 8'd171;
        end else if (c == 32'hC2AB || c == 32'hC2BB ||
                     (c >= 32'hE2809C && c <= 32'hE2809F)) begin
            res.glyph = 8'd2;
        end else if (c >= 32'hE28098 && c <= 32'hE2809B) begin
            res.glyph = 8'd7;
        end else if (c >= 32'hE28090 && c <= 32'hE28095) begin
            res.glyph = 8'd13;
        end else if (c == 32'hE280A6) begin
            res.glyph = 8'd172;
        end else if (c == 32'hC2A0) begin
            res.glyph = 8'd0;
        end else if (c == 32'hE28496) begin
            res.glyph = 8'd3;
        end
        return res;
    endfunction

endpackage

// File: rtl/utf8_glyph_index_mapper.sv
// utf8 glyph index mapper: one text byte per cycle unless a held result stalls it; the
// last byte of a sequence passes the input byte register, then the decode, then the
// result register before its glyph shows on m_valid. sustained throughput is one byte
// per cycle while m_ready takes each result. synchronous active-low reset clears the valid
// flags and the pending-sequence state.
// depends on u8gim_pkg
module utf8_glyph_index_mapper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_glyph_index,
    output logic       m_font_select
);
    import u8gim_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [1:0]  rem_reg;
    logic [1:0]  rem_next;
    logic [23:0] acc_reg;
    logic [23:0] acc_next;
    logic        out_valid_reg;
    logic [7:0]  out_glyph_reg;
    logic        out_font_reg;

    logic        has_result;
    logic [31:0] code;
    glyph_res_t  mapped;
    logic        advance;

    // sequence assembly and state update for the held byte
    always_comb begin
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        has_result = 1'b0;
        code       = {24'd0, in_byte_reg};
        if (in_byte_reg == 8'd0) begin
            rem_next = 2'd0;
            acc_next = 24'd0;
        end else if (rem_reg != 2'd0) begin
            acc_next = {acc_reg[15:0], in_byte_reg};
            rem_next = rem_reg - 2'd1;
            code     = {acc_reg, in_byte_reg};
            if (rem_reg == 2'd1) begin
                has_result = 1'b1;
                acc_next   = 24'd0;
            end
        end else if (in_byte_reg[7:5] == LEAD2_PFX) begin
            acc_next = {16'd0, in_byte_reg};
            rem_next = 2'd1;
        end else if (in_byte_reg[7:4] == LEAD3_PFX) begin
            acc_next = {16'd0, in_byte_reg};
            rem_next = 2'd2;
        end else if (in_byte_reg[7:3] == LEAD4_PFX) begin
            acc_next = {16'd0, in_byte_reg};
            rem_next = 2'd3;
        end else begin
            has_result = 1'b1;
        end
    end

    assign mapped = map_code(code);

    // held item moves on when it makes no result or the result register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready || !has_result);
    assign s_ready = !in_valid_reg || advance;

    // input byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
    end

    // pending sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            acc_reg <= 24'd0;
        end else if (advance) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && has_result) begin
            out_glyph_reg <= mapped.glyph;
            out_font_reg  <= mapped.font;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_glyph_index = out_glyph_reg;
    assign m_font_select = out_font_reg;

endmodule

// File: rtl/u8gim_checker.sv
// port-level checker for the utf8 glyph index mapper, bound to the top level
// depends on utf8_glyph_index_mapper_assert.svh
`include "utf8_glyph_index_mapper_assert.svh"

module u8gim_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_text_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_glyph_index,
    input logic       m_font_select
);

    // colon-substitute font has only nine glyphs
    `U8GIM_ASSERT_IMP(a_font_range, aclk, aresetn, m_valid && m_font_select, m_glyph_index <= 8'd8, "colon font glyph out of range")

    // main font index never past the last glyph
    `U8GIM_ASSERT_IMP(a_glyph_range, aclk, aresetn, m_valid, m_glyph_index <= 8'd172, "glyph index out of range")

    // a stalled result item holds
    `U8GIM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_glyph_index) && $stable(m_font_select), "result item changed while stalled")

endmodule

bind utf8_glyph_index_mapper u8gim_checker u_u8gim_checker (.*);
